// ===== sv/cnk_pkg.sv =====
package cnk_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam int NUM_SLOTS = 8;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SELF_ID     = 2'd0,
    REG_ROOT_ID     = 2'd1,
    REG_PING_PERIOD = 2'd2
  } cnk_reg_t;

  localparam logic [15:0] PING_PERIOD_RESET = 16'd1000;
  localparam logic [7:0]  ROOT_ID_RESET     = 8'd0;
  localparam logic signed [8:0] ID_UNKNOWN  = -9'sd1;

  // action codes
  localparam logic [2:0] ACT_TO_MASTER    = 3'd0;
  localparam logic [2:0] ACT_TO_SLAVE     = 3'd1;
  localparam logic [2:0] ACT_FLUSH_SLAVE  = 3'd2;
  localparam logic [2:0] ACT_FLUSH_MASTER = 3'd3;
  localparam logic [2:0] ACT_REPORT       = 3'd4;

  // handshake kinds
  localparam logic [1:0] HS_MTS     = 2'd0;
  localparam logic [1:0] HS_MTS_ACK = 2'd1;
  localparam logic [1:0] HS_STM     = 2'd2;
  localparam logic [1:0] HS_STM_ACK = 2'd3;

  localparam logic OP_MESSAGE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // result slots, emitted lowest first
  localparam int SLOT_FLUSH_SLAVE  = 0;
  localparam int SLOT_REPORT_A     = 1;  // after slave check, old master id
  localparam int SLOT_FLUSH_MASTER = 2;
  localparam int SLOT_REPORT_B     = 3;  // with current master id
  localparam int SLOT_PING_SLAVE   = 4;
  localparam int SLOT_PING_MASTER  = 5;
  localparam int SLOT_ACK_MASTER   = 6;
  localparam int SLOT_ACK_SLAVE    = 7;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    logic [7:0]           root;
    logic signed [8:0]    rep_a_master;
    logic signed [8:0]    rep_b_master;
    logic signed [8:0]    rep_slave;
  } cnk_job_t;

endpackage

// ===== sv/cnk_front.sv =====
module cnk_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,
  input  logic [0:0]        s_tuser,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              q_full,
  output logic              q_push,
  output cnk_pkg::cnk_job_t q_job
);

  logic [7:0]        root_id;
  logic [15:0]       ping_period;
  logic signed [8:0] master_node, master_node_next;
  logic signed [8:0] slave_node, slave_node_next;
  logic              down_ack_seen, down_ack_seen_next;
  logic signed [8:0] down_ack_sender, down_ack_sender_next;
  logic              up_ack_seen, up_ack_seen_next;
  logic signed [8:0] up_ack_sender, up_ack_sender_next;
  logic [15:0]       round_timer, round_timer_next;
  logic              round_started, round_started_next;

  logic              accept;
  logic              op;
  logic [1:0]        hs;
  logic signed [8:0] sender;
  logic [15:0]       period;
  logic [15:0]       timer_inc;

  assign s_tready  = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign op        = s_tuser[0];
  assign hs        = s_tdata[1:0];
  assign sender    = $signed({1'b0, s_tdata[9:2]});
  assign period    = (ping_period == 16'd0) ? 16'd1 : ping_period;
  assign timer_inc = round_timer + 16'd1;

  always_comb begin
    master_node_next     = master_node;
    slave_node_next      = slave_node;
    down_ack_seen_next   = down_ack_seen;
    down_ack_sender_next = down_ack_sender;
    up_ack_seen_next     = up_ack_seen;
    up_ack_sender_next   = up_ack_sender;
    round_timer_next     = round_timer;
    round_started_next   = round_started;
    q_job.mask           = '0;
    q_job.root           = root_id;
    q_job.rep_a_master   = master_node;
    q_job.rep_b_master   = master_node;
    q_job.rep_slave      = slave_node;
    if (op == cnk_pkg::OP_TICK) begin
      if (!round_started) begin
        round_started_next = 1'b1;
        round_timer_next   = '0;
        down_ack_seen_next = 1'b0;
        up_ack_seen_next   = 1'b0;
        q_job.mask[cnk_pkg::SLOT_PING_SLAVE]  = 1'b1;
        q_job.mask[cnk_pkg::SLOT_PING_MASTER] = 1'b1;
      end else if (timer_inc >= period) begin
        round_timer_next = '0;
        // slave side: a loss is reported even when already unknown
        if (down_ack_seen) begin
          if (down_ack_sender != slave_node) begin
            slave_node_next = down_ack_sender;
            q_job.mask[cnk_pkg::SLOT_FLUSH_SLAVE] = 1'b1;
            q_job.mask[cnk_pkg::SLOT_REPORT_A]    = 1'b1;
          end
        end else begin
          slave_node_next = cnk_pkg::ID_UNKNOWN;
          q_job.mask[cnk_pkg::SLOT_REPORT_A] = 1'b1;
        end
        // master side: a loss goes unreported
        if (up_ack_seen) begin
          if (up_ack_sender != master_node) begin
            master_node_next = up_ack_sender;
            q_job.mask[cnk_pkg::SLOT_FLUSH_MASTER] = 1'b1;
            q_job.mask[cnk_pkg::SLOT_REPORT_B]     = 1'b1;
          end
        end else begin
          master_node_next = cnk_pkg::ID_UNKNOWN;
        end
        down_ack_seen_next = 1'b0;
        up_ack_seen_next   = 1'b0;
        q_job.mask[cnk_pkg::SLOT_PING_SLAVE]  = 1'b1;
        q_job.mask[cnk_pkg::SLOT_PING_MASTER] = 1'b1;
        q_job.rep_b_master = master_node_next;
        q_job.rep_slave    = slave_node_next;
      end else begin
        round_timer_next = timer_inc;
      end
    end else begin
      case (hs)
        cnk_pkg::HS_MTS: begin
          if (sender != master_node) begin
            master_node_next = sender;
            q_job.mask[cnk_pkg::SLOT_REPORT_B] = 1'b1;
          end
          q_job.mask[cnk_pkg::SLOT_ACK_MASTER] = 1'b1;
          q_job.rep_b_master = sender;
        end
        cnk_pkg::HS_MTS_ACK: begin
          down_ack_sender_next = sender;
          down_ack_seen_next   = 1'b1;
        end
        cnk_pkg::HS_STM: begin
          if (sender != slave_node) begin
            slave_node_next = sender;
            q_job.mask[cnk_pkg::SLOT_REPORT_B] = 1'b1;
          end
          q_job.mask[cnk_pkg::SLOT_ACK_SLAVE] = 1'b1;
          q_job.rep_slave = sender;
        end
        default: begin
          up_ack_sender_next = sender;
          up_ack_seen_next   = 1'b1;
        end
      endcase
    end
  end

  assign q_push = accept && (q_job.mask != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      root_id         <= cnk_pkg::ROOT_ID_RESET;
      ping_period     <= cnk_pkg::PING_PERIOD_RESET;
      master_node     <= cnk_pkg::ID_UNKNOWN;
      slave_node      <= cnk_pkg::ID_UNKNOWN;
      down_ack_seen   <= 1'b0;
      down_ack_sender <= cnk_pkg::ID_UNKNOWN;
      up_ack_seen     <= 1'b0;
      up_ack_sender   <= cnk_pkg::ID_UNKNOWN;
      round_timer     <= '0;
      round_started   <= 1'b0;
    end else begin
      // self id shows in no result, so it is not held
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cnk_pkg::REG_ROOT_ID:     root_id     <= cfg_data[7:0];
          cnk_pkg::REG_PING_PERIOD: ping_period <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        master_node     <= master_node_next;
        slave_node      <= slave_node_next;
        down_ack_seen   <= down_ack_seen_next;
        down_ack_sender <= down_ack_sender_next;
        up_ack_seen     <= up_ack_seen_next;
        up_ack_sender   <= up_ack_sender_next;
        round_timer     <= round_timer_next;
        round_started   <= round_started_next;
      end
    end
  end

endmodule

// ===== sv/cnk_queue.sv =====
module cnk_queue #(
  parameter int DEPTH = cnk_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cnk_pkg::cnk_job_t push_job,
  output logic              full,
  input  logic              pop,
  output cnk_pkg::cnk_job_t head,
  output logic              empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  cnk_pkg::cnk_job_t entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == DEPTH_C);
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: ;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CW'(1)))
    else $error("queue count lost a push");

endmodule

// ===== sv/cnk_back.sv =====
module cnk_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  cnk_pkg::cnk_job_t q_head,
  output logic              q_pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,
  output logic              m_tlast
);

  localparam int SW = $clog2(cnk_pkg::NUM_SLOTS);

  cnk_pkg::cnk_job_t           cur;
  logic [cnk_pkg::NUM_SLOTS-1:0] remaining;
  logic [SW-1:0]               slot;
  logic                        busy;
  logic                        emit;
  logic [2:0]                  action;
  logic [1:0]                  hs_out;
  logic signed [8:0]           dest;
  logic signed [8:0]           rep_m;
  logic signed [8:0]           rep_s;

  assign busy = (cur.mask != '0);
  assign emit = busy && (!m_tvalid || m_tready);

  always_comb begin
    slot = '0;
    for (int i = cnk_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (cur.mask[i]) slot = SW'(i);
    end
    remaining       = cur.mask;
    remaining[slot] = 1'b0;
  end

  assign q_pop = !q_empty && (!busy || (emit && remaining == '0));

  always_comb begin
    action = cnk_pkg::ACT_TO_MASTER;
    hs_out = cnk_pkg::HS_MTS;
    dest   = cnk_pkg::ID_UNKNOWN;
    rep_m  = '0;
    rep_s  = '0;
    case (int'(slot))
      cnk_pkg::SLOT_FLUSH_SLAVE:  action = cnk_pkg::ACT_FLUSH_SLAVE;
      cnk_pkg::SLOT_FLUSH_MASTER: action = cnk_pkg::ACT_FLUSH_MASTER;
      cnk_pkg::SLOT_REPORT_A, cnk_pkg::SLOT_REPORT_B: begin
        action = cnk_pkg::ACT_REPORT;
        dest   = $signed({1'b0, cur.root});
        rep_m  = (int'(slot) == cnk_pkg::SLOT_REPORT_A) ? cur.rep_a_master : cur.rep_b_master;
        rep_s  = cur.rep_slave;
      end
      cnk_pkg::SLOT_PING_SLAVE: begin
        action = cnk_pkg::ACT_TO_SLAVE;
        hs_out = cnk_pkg::HS_MTS;
      end
      cnk_pkg::SLOT_PING_MASTER: begin
        action = cnk_pkg::ACT_TO_MASTER;
        hs_out = cnk_pkg::HS_STM;
      end
      cnk_pkg::SLOT_ACK_MASTER: begin
        action = cnk_pkg::ACT_TO_MASTER;
        hs_out = cnk_pkg::HS_MTS_ACK;
      end
      default: begin
        action = cnk_pkg::ACT_TO_SLAVE;
        hs_out = cnk_pkg::HS_STM_ACK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.mask <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur <= q_head;
      end else if (emit) begin
        cur.mask <= remaining;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {rep_s, rep_m, dest, hs_out, action};
      m_tlast <= (remaining == '0);
    end
  end

endmodule

// ===== sv/chain_neighbor_keepalive_core.sv =====
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tdata: hs_type_in, sender; tuser: op
// m_*      out  m_tvalid/m_tready  tdata: action, hs_type_out, dest_id,
//                                  report_master, report_slave; tlast: last
// cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// An item is taken every cycle while the job queue (QUEUE_DEPTH entries) has room;
// neighbour state is updated in the same cycle.
// The back end emits one result per cycle while m_tready allows, so an item with n results
// occupies it until all are out (up to six for a tick round); the output register sets that pace.
// Reset is synchronous; no clearing pass. cfg_ready is always high.
// A stall on the m side fills the queue and then holds s_tready low.
module chain_neighbor_keepalive_core #(
  parameter int QUEUE_DEPTH = cnk_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // hs_type_in[1:0], sender[9:2], zero fill
  input  logic [0:0]  s_tuser,   // op[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // action[2:0], hs_type_out[4:3], dest_id[13:5],
                                 // report_master[22:14], report_slave[31:23]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cnk_pkg::cnk_job_t push_job;
  cnk_pkg::cnk_job_t head_job;
  logic              push;
  logic              pop;
  logic              full;
  logic              empty;

  cnk_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (full),
    .q_push    (push),
    .q_job     (push_job)
  );

  cnk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head     (head_job),
    .empty    (empty)
  );

  cnk_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (empty),
    .q_head   (head_job),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== tb/sv/chain_neighbor_keepalive_core_tb.sv =====
`timescale 1ns / 1ps

module chain_neighbor_keepalive_core_tb;
  import cnk_pkg::*;

  localparam int LIMIT     = 200000;
  localparam int HOLD_LONG = 300;
  localparam int SETTLE    = 20;

  typedef struct {
    logic [2:0]        action;
    logic [1:0]        kind;
    logic signed [8:0] dest;
    logic signed [8:0] rep_master;
    logic signed [8:0] rep_slave;
    logic              last;
  } chain_result_t;

  class keepalive_scoreboard;
    logic [7:0]        self_id;
    logic [7:0]        root_id;
    logic [15:0]       period;
    logic signed [8:0] upstream_id;
    logic signed [8:0] downstream_id;
    logic signed [8:0] down_ack_id;
    logic signed [8:0] up_ack_id;
    bit                down_ack;
    bit                up_ack;
    bit                started;
    logic [15:0]       tick_count;
    chain_result_t     pending_results[$];
    chain_result_t     batch[$];
    int                mismatches;
    int                results_seen;
    int                items_seen;
    int                rounds;
    int                writes;

    function new();
      self_id     = 8'd1;
      root_id     = ROOT_ID_RESET;
      period      = PING_PERIOD_RESET;
      upstream_id   = ID_UNKNOWN;
      downstream_id = ID_UNKNOWN;
      down_ack_id = ID_UNKNOWN;
      up_ack_id   = ID_UNKNOWN;
      down_ack    = 1'b0;
      up_ack      = 1'b0;
      started     = 1'b0;
      tick_count  = '0;
      mismatches  = 0;
      results_seen = 0;
      items_seen  = 0;
      rounds      = 0;
      writes      = 0;
    endfunction

    function void note_config(cnk_reg_t idx, logic [15:0] value);
      writes++;
      case (idx)
        REG_SELF_ID:     self_id = value[7:0];
        REG_ROOT_ID:     root_id = value[7:0];
        REG_PING_PERIOD: period = value;
        default: ;
      endcase
    endfunction

    function void add(logic [2:0] action, logic [1:0] kind, logic signed [8:0] dest,
                      logic signed [8:0] rm, logic signed [8:0] rs);
      chain_result_t r;
      r.action     = action;
      r.kind       = kind;
      r.dest       = dest;
      r.rep_master = rm;
      r.rep_slave  = rs;
      r.last       = 1'b0;
      batch.push_back(r);
    endfunction

    // ids as they stand at the moment the report goes out
    function void report();
      add(ACT_REPORT, '0, $signed({1'b0, root_id}), upstream_id, downstream_id);
    endfunction

    function void pings();
      down_ack = 1'b0;
      up_ack   = 1'b0;
      add(ACT_TO_SLAVE, HS_MTS, ID_UNKNOWN, '0, '0);
      add(ACT_TO_MASTER, HS_STM, ID_UNKNOWN, '0, '0);
    endfunction

    function void accept_item(logic op, logic [1:0] kind, logic [7:0] sender);
      logic signed [8:0] who;
      logic [15:0]       eff;
      batch.delete();
      items_seen++;
      who = $signed({1'b0, sender});
      if (op == OP_TICK) begin
        if (!started) begin
          started    = 1'b1;
          tick_count = '0;
          pings();
        end else begin
          eff = (period == 16'd0) ? 16'd1 : period;
          tick_count = tick_count + 16'd1;
          if (tick_count >= eff) begin
            tick_count = '0;
            rounds++;
            if (down_ack) begin
              if (down_ack_id != downstream_id) begin
                downstream_id = down_ack_id;
                add(ACT_FLUSH_SLAVE, '0, ID_UNKNOWN, '0, '0);
                report();
              end
            end else begin
              // a silent slave is reported every round, even if already unknown
              downstream_id = ID_UNKNOWN;
              report();
            end
            if (up_ack) begin
              if (up_ack_id != upstream_id) begin
                upstream_id = up_ack_id;
                add(ACT_FLUSH_MASTER, '0, ID_UNKNOWN, '0, '0);
                report();
              end
            end else begin
              upstream_id = ID_UNKNOWN;
            end
            pings();
          end
        end
      end else begin
        case (kind)
          HS_MTS: begin
            if (who != upstream_id) begin
              upstream_id = who;
              report();
            end
            add(ACT_TO_MASTER, HS_MTS_ACK, ID_UNKNOWN, '0, '0);
          end
          HS_MTS_ACK: begin
            down_ack_id = who;
            down_ack    = 1'b1;
          end
          HS_STM: begin
            if (who != downstream_id) begin
              downstream_id = who;
              report();
            end
            add(ACT_TO_SLAVE, HS_STM_ACK, ID_UNKNOWN, '0, '0);
          end
          default: begin
            up_ack_id = who;
            up_ack    = 1'b1;
          end
        endcase
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) pending_results.push_back(batch[i]);
    endfunction

    function void check_result(logic [31:0] data, logic last_bit);
      chain_result_t got;
      chain_result_t want;
      got.action     = data[2:0];
      got.kind       = data[4:3];
      got.dest       = $signed(data[13:5]);
      got.rep_master = $signed(data[22:14]);
      got.rep_slave  = $signed(data[31:23]);
      got.last       = last_bit;
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: unexpected transfer, data %h last %b",
                   results_seen, data, last_bit);
        return;
      end
      want = pending_results.pop_front();
      if (got.action !== want.action || got.kind !== want.kind || got.dest !== want.dest ||
          got.rep_master !== want.rep_master || got.rep_slave !== want.rep_slave ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d: expected act %0d hs %0d dest %0d mst %0d slv %0d last %b",
                   results_seen, want.action, want.kind, want.dest, want.rep_master,
                   want.rep_slave, want.last);
          $display("result %0d:      got act %0d hs %0d dest %0d mst %0d slv %0d last %b",
                   results_seen, got.action, got.kind, got.dest, got.rep_master,
                   got.rep_slave, got.last);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  keepalive_scoreboard sb;
  int          cycle_count;
  bit          hold_request;
  logic [7:0]  neighbor_a;
  logic [7:0]  neighbor_b;

  chain_neighbor_keepalive_core uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               sb.pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // outputs are sampled mid-cycle, inputs change only at the rising edge
  always @(negedge clk) begin
    if (rst === 1'b0 && m_tvalid === 1'b1 && m_tready === 1'b1)
      sb.check_result(m_tdata, m_tlast);
  end

  // receiver: segments of steady, light and heavy back-pressure, plus one long hold-off
  initial begin
    int seg_len;
    int mode;
    int k;
    forever begin
      mode    = $urandom_range(0, 2);
      seg_len = $urandom_range(4, 40);
      for (k = 0; k < seg_len; k++) begin
        @(posedge clk);
        if (hold_request) begin
          m_tready <= 1'b0;
          repeat (HOLD_LONG) @(posedge clk);
          hold_request = 1'b0;
        end else begin
          case (mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 9) < 7);
            default: m_tready <= ($urandom_range(0, 9) < 3);
          endcase
        end
      end
    end
  end

  task automatic send_item(logic op, logic [1:0] kind, logic [7:0] sender);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'b0, sender, kind};
    do @(negedge clk); while (s_tready !== 1'b1);
    sb.accept_item(op, kind, sender);
    @(posedge clk);
  endtask

  task automatic write_reg(cnk_reg_t idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk); while (cfg_ready !== 1'b1);
    sb.note_config(idx, value);
    @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] self_v, logic [15:0] root_v, logic [15:0] period_v);
    write_reg(REG_SELF_ID, self_v);
    write_reg(REG_ROOT_ID, root_v);
    write_reg(REG_PING_PERIOD, period_v);
    cfg_valid <= 1'b0;
  endtask

  // silent items (acks, ticks between rounds) push nothing into the queue
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_item();
    logic [7:0] who;
    logic [1:0] kind;
    int         r;
    r    = $urandom_range(0, 99);
    kind = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) who = 8'($urandom_range(0, 255));
    else who = $urandom_range(0, 1) ? neighbor_a : neighbor_b;
    if (r < 30) send_item(OP_TICK, kind, who);
    else send_item(OP_MESSAGE, kind, who);
  endtask

  task automatic run_traffic(int count, bit with_pressure);
    int sent;
    int burst;
    int gap;
    int k;
    sent = 0;
    neighbor_a = 8'($urandom_range(0, 255));
    neighbor_b = 8'($urandom_range(0, 255));
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (k = 0; k < burst && sent < count; k++) begin
        if (with_pressure && sent == count / 3) hold_request = 1'b1;
        if (with_pressure && sent == (2 * count) / 3) drain();
        random_item();
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    sb           = new();
    cycle_count  = 0;
    hold_request = 1'b0;
    neighbor_a   = '0;
    neighbor_b   = '0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    m_tready  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_SELF_ID;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_config(16'd0, 16'd254, 16'd2);
    send_item(OP_TICK, HS_MTS, 8'd0);          // first tick: pings only
    send_item(OP_MESSAGE, HS_MTS, 8'd0);       // new master, report then ack
    send_item(OP_MESSAGE, HS_MTS, 8'd0);       // same master, ack alone
    send_item(OP_MESSAGE, HS_STM, 8'd255);     // out-of-range id kept as is
    send_item(OP_MESSAGE, HS_STM, 8'd254);
    send_item(OP_MESSAGE, HS_MTS_ACK, 8'd7);
    send_item(OP_MESSAGE, HS_STM_ACK, 8'd9);
    send_item(OP_TICK, HS_STM_ACK, 8'hFF);     // mid-round tick, silent
    send_item(OP_TICK, HS_MTS, 8'd0);          // both neighbours changed: six results
    send_item(OP_MESSAGE, HS_MTS_ACK, 8'd7);
    send_item(OP_MESSAGE, HS_STM_ACK, 8'd9);
    send_item(OP_TICK, HS_MTS, 8'd0);
    send_item(OP_TICK, HS_MTS, 8'd0);          // unchanged: pings only
    send_item(OP_TICK, HS_MTS, 8'd0);
    send_item(OP_TICK, HS_MTS, 8'd0);          // both lost; master loss is silent
    send_item(OP_TICK, HS_MTS, 8'd0);
    send_item(OP_TICK, HS_MTS, 8'd0);          // slave unknown and silent, reported again
    send_item(OP_MESSAGE, HS_MTS_ACK, 8'd255);
    send_item(OP_MESSAGE, HS_STM_ACK, 8'd255);
    send_item(OP_TICK, HS_STM, 8'd128);
    send_item(OP_TICK, HS_STM, 8'd127);
    send_item(OP_MESSAGE, HS_MTS, 8'd128);
    send_item(OP_MESSAGE, HS_STM, 8'd127);
    drain();

    set_config(16'($urandom_range(0, 65535)), 16'd0, 16'd1);
    run_traffic(60, 1'b0);
    drain();
    // zero period behaves as one; upper data bits of the id registers are dropped
    set_config(16'd254, 16'h5AFF, 16'd0);
    run_traffic(60, 1'b1);
    drain();
    set_config(16'd255, 16'd128, 16'd65535);
    run_traffic(20, 1'b0);
    drain();
    set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 254)), 16'd3);
    run_traffic(70, 1'b0);
    drain();
    set_config(16'($urandom_range(0, 254)), 16'($urandom_range(0, 255)),
               16'($urandom_range(1, 6)));
    run_traffic(70, 1'b0);
    drain();
    set_config(16'($urandom_range(0, 254)), 16'($urandom_range(0, 254)), 16'd4);
    run_traffic(70, 1'b0);
    drain();

    $display("covered %0d input transfers, %0d result transfers, %0d ping rounds checked",
             sb.items_seen, sb.results_seen, sb.rounds);
    $display("%0d register writes across seven settings incl. zero and maximal ping period; "
             , sb.writes, "%0d mismatches", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
